// ===== sv/sor_pkg.sv =====
package sor_pkg;
  localparam int CANVAS_WIDTH  = 64;
  localparam int CANVAS_HEIGHT = 32;
  localparam int COL_W = $clog2(CANVAS_WIDTH);
  localparam int ROW_W = $clog2(CANVAS_HEIGHT);
  localparam int CELL_COUNT = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CODE_W = 7;
  localparam int CRD_W = 12;
  localparam logic [CODE_W-1:0] SPACE_CODE = 7'd32;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_DRAW   = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [1:0] SHP_CIRCLE = 2'd0;
  localparam logic [1:0] SHP_RECT   = 2'd1;
  localparam logic [1:0] SHP_LINE   = 2'd2;
  localparam logic [1:0] SHP_TRI    = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] shape_kind;
    logic [5:0] point1_x;
    logic [4:0] point1_y;
    logic [5:0] point2_x;
    logic [4:0] point2_y;
    logic [5:0] point3_x;
    logic [4:0] point3_y;
    logic [5:0] radius;
    logic [6:0] glyph;
    logic [4:0] read_row;
    logic [5:0] read_col;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] cell_value;
    logic [1:0] done_action;
  } out_beat_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] xa;
    logic signed [CRD_W-1:0] ya;
    logic signed [CRD_W-1:0] xb;
    logic signed [CRD_W-1:0] yb;
  } seg_t;

  typedef struct packed {
    logic line_start;
    logic line_step;
    logic circ_start;
    logic circ_step;
    seg_t seg;
    logic signed [CRD_W-1:0] cx;
    logic signed [CRD_W-1:0] cy;
    logic [5:0] rad;
  } dp_cmd_t;

  typedef struct packed {
    logic line_last;
    logic circ_last;
    logic plot_ok;
    logic [ADDR_W-1:0] plot_addr;
  } dp_sts_t;
endpackage

// ===== sv/sor_ram.sv =====
module sor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/sor_datapath.sv =====
module sor_datapath (
  input  logic             clk,
  input  sor_pkg::dp_cmd_t cmd,
  output sor_pkg::dp_sts_t sts
);
  import sor_pkg::*;

  logic signed [CRD_W-1:0] x, y, xb, yb, dx, dy, err, sx, sy;
  logic signed [CRD_W-1:0] e2;
  logic signed [CRD_W-1:0] cxr, cyr, cx0, cy0, cerr, cerr1, cerr2;
  logic [2:0] oct;
  logic circ_mode;
  logic signed [CRD_W-1:0] px, py, ox, oy;
  logic [ADDR_W-1:0] lin;

  assign e2 = err <<< 1;

  always_ff @(posedge clk) begin
    if (cmd.line_start) begin
      circ_mode <= 1'b0;
      x  <= cmd.seg.xa;
      y  <= cmd.seg.ya;
      xb <= cmd.seg.xb;
      yb <= cmd.seg.yb;
      dx <= (cmd.seg.xb >= cmd.seg.xa) ? cmd.seg.xb - cmd.seg.xa : cmd.seg.xa - cmd.seg.xb;
      dy <= (cmd.seg.yb >= cmd.seg.ya) ? cmd.seg.yb - cmd.seg.ya : cmd.seg.ya - cmd.seg.yb;
      sx <= (cmd.seg.xb >= cmd.seg.xa) ? CRD_W'(1) : -CRD_W'(1);
      sy <= (cmd.seg.yb >= cmd.seg.ya) ? CRD_W'(1) : -CRD_W'(1);
      err <= ((cmd.seg.xb >= cmd.seg.xa) ? cmd.seg.xb - cmd.seg.xa : cmd.seg.xa - cmd.seg.xb)
           - ((cmd.seg.yb >= cmd.seg.ya) ? cmd.seg.yb - cmd.seg.ya : cmd.seg.ya - cmd.seg.yb);
    end else if (cmd.line_step) begin
      if (e2 > -dy && e2 < dx) begin
        err <= err - dy + dx;
      end else if (e2 > -dy) begin
        err <= err - dy;
      end else if (e2 < dx) begin
        err <= err + dx;
      end
      if (e2 > -dy) x <= x + sx;
      if (e2 < dx) y <= y + sy;
    end
    if (cmd.circ_start) begin
      circ_mode <= 1'b1;
      cx0 <= cmd.cx;
      cy0 <= cmd.cy;
      cxr <= CRD_W'(cmd.rad);
      cyr <= '0;
      cerr <= '0;
      oct <= '0;
    end else if (cmd.circ_step) begin
      oct <= oct + 3'd1;
      if (oct == 3'd7) begin
        cyr <= cyr + CRD_W'(1);
        if (cerr2 > 0) begin
          cxr  <= cxr - CRD_W'(1);
          cerr <= CRD_W'(cerr1 + 1 - ((cxr - 1) <<< 1));
        end else begin
          cerr <= cerr1;
        end
      end
    end
  end

  assign cerr1 = CRD_W'(cerr + 1 + ((cyr + 1) <<< 1));
  assign cerr2 = CRD_W'(((cerr1 - cxr) <<< 1) + 1);

  always_comb begin
    ox = '0;
    oy = '0;
    unique case (oct)
      3'd0: begin ox =  cxr; oy =  cyr; end
      3'd1: begin ox =  cyr; oy =  cxr; end
      3'd2: begin ox = -cyr; oy =  cxr; end
      3'd3: begin ox = -cxr; oy =  cyr; end
      3'd4: begin ox = -cxr; oy = -cyr; end
      3'd5: begin ox = -cyr; oy = -cxr; end
      3'd6: begin ox =  cyr; oy = -cxr; end
      default: begin ox = cxr; oy = -cyr; end
    endcase
    px = circ_mode ? cx0 + ox : x;
    py = circ_mode ? cy0 + oy : y;
    lin = {py[ROW_W-1:0], px[COL_W-1:0]};
  end

  assign sts.plot_ok = (px >= 0) && (px < CANVAS_WIDTH) && (py >= 0) && (py < CANVAS_HEIGHT);
  assign sts.plot_addr = lin;
  assign sts.line_last = (x == xb) && (y == yb);
  assign sts.circ_last = (oct == 3'd7) && !((cyr + 1) <= ((cerr2 > 0) ? cxr - 1 : cxr));
endmodule

// ===== sv/sor_ctrl.sv =====
module sor_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  sor_pkg::in_beat_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sor_pkg::out_beat_t         out_data,
  input  logic [6:0]                 bg,
  output sor_pkg::dp_cmd_t           cmd,
  input  sor_pkg::dp_sts_t           sts,
  output logic                       we,
  output logic [sor_pkg::ADDR_W-1:0] waddr,
  output logic [6:0]                 wdata,
  output logic [sor_pkg::ADDR_W-1:0] raddr,
  input  logic [6:0]                 rdata
);
  import sor_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_FILL, S_LSETUP, S_LINE, S_CIRC, S_READ, S_READ2
  } state_t;

  state_t state;
  in_beat_t op;
  logic [ADDR_W-1:0] fcnt;
  logic [6:0] fcode;
  logic [1:0] seg_idx;
  logic [2:0] seg_n;
  logic signed [CRD_W-1:0] lft, rgt, top, bot;
  seg_t cur_seg;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    lft = CRD_W'(op.point1_x < op.point2_x ? op.point1_x : op.point2_x);
    rgt = CRD_W'(op.point1_x > op.point2_x ? op.point1_x : op.point2_x);
    top = CRD_W'(op.point1_y < op.point2_y ? op.point1_y : op.point2_y);
    bot = CRD_W'(op.point1_y > op.point2_y ? op.point1_y : op.point2_y);
    cur_seg = '{CRD_W'(op.point1_x), CRD_W'(op.point1_y), CRD_W'(op.point2_x), CRD_W'(op.point2_y)};
    if (op.shape_kind == SHP_RECT) begin
      unique case (seg_idx)
        2'd0: cur_seg = '{lft, top, rgt, top};
        2'd1: cur_seg = '{lft, bot, rgt, bot};
        2'd2: cur_seg = '{lft, top, lft, bot};
        default: cur_seg = '{rgt, top, rgt, bot};
      endcase
    end else if (op.shape_kind == SHP_TRI) begin
      unique case (seg_idx)
        2'd0: cur_seg = '{CRD_W'(op.point1_x), CRD_W'(op.point1_y),
                          CRD_W'(op.point2_x), CRD_W'(op.point2_y)};
        2'd1: cur_seg = '{CRD_W'(op.point2_x), CRD_W'(op.point2_y),
                          CRD_W'(op.point3_x), CRD_W'(op.point3_y)};
        default: cur_seg = '{CRD_W'(op.point3_x), CRD_W'(op.point3_y),
                             CRD_W'(op.point1_x), CRD_W'(op.point1_y)};
      endcase
    end
    cmd.seg = cur_seg;
    cmd.cx = CRD_W'(op.point1_x);
    cmd.cy = CRD_W'(op.point1_y);
    cmd.rad = op.radius;
    cmd.line_start = (state == S_LSETUP) && (op.shape_kind != SHP_CIRCLE);
    cmd.line_step = (state == S_LINE);
    cmd.circ_start = (state == S_LSETUP) && (op.shape_kind == SHP_CIRCLE);
    cmd.circ_step = (state == S_CIRC);
    we = 1'b0;
    waddr = sts.plot_addr;
    wdata = op.glyph;
    if (state == S_INIT || state == S_FILL) begin
      we = 1'b1;
      waddr = fcnt;
      wdata = fcode;
    end else if (state == S_LINE || state == S_CIRC) begin
      we = sts.plot_ok;
    end
    raddr = ADDR_W'({op.read_row, op.read_col});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      fcnt <= '0;
      fcode <= SPACE_CODE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_INIT, S_FILL: begin
          fcnt <= fcnt + 1'b1;
          if (fcnt == ADDR_W'(CELL_COUNT - 1)) begin
            if (state == S_FILL) begin
              out_valid <= 1'b1;
              out_data <= '{7'd0, ACT_CLEAR};
            end
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= in_data;
            seg_idx <= '0;
            fcnt <= '0;
            fcode <= bg;
            seg_n <= (in_data.shape_kind == SHP_RECT) ? 3'd4 :
                     (in_data.shape_kind == SHP_TRI) ? 3'd3 : 3'd1;
            unique case (in_data.action)
              ACT_CLEAR: state <= S_FILL;
              ACT_DRAW: state <= S_LSETUP;
              ACT_READ: state <= S_READ;
              default: begin
                out_valid <= 1'b1;
                out_data <= '{7'd0, in_data.action};
              end
            endcase
          end
        end
        S_LSETUP: state <= (op.shape_kind == SHP_CIRCLE) ? S_CIRC : S_LINE;
        S_LINE: begin
          if (sts.line_last) begin
            if (3'(seg_idx) + 3'd1 == seg_n) begin
              out_valid <= 1'b1;
              out_data <= '{7'd0, ACT_DRAW};
              state <= S_IDLE;
            end else begin
              seg_idx <= seg_idx + 2'd1;
              state <= S_LSETUP;
            end
          end
        end
        S_CIRC: begin
          if (sts.circ_last) begin
            out_valid <= 1'b1;
            out_data <= '{7'd0, ACT_DRAW};
            state <= S_IDLE;
          end
        end
        S_READ: state <= S_READ2;
        default: begin
          out_valid <= 1'b1;
          out_data <= '{rdata, ACT_READ};
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== sv/shape_outline_rasterizer_core.sv =====
// Channel | Signals                      | Beat
// in      | in_valid in_ready in_data    | one command (in_beat_t)
// out     | out_valid out_ready out_data | one completion (out_beat_t)
// cfg     | cfg_we cfg_data              | background code
// Reset starts a fill of the frame RAM with space; no beat is taken meanwhile.
// A completion waits in the output register; the next command waits until it is taken.
module shape_outline_rasterizer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sor_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sor_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data
);
  import sor_pkg::*;

  logic [6:0] bg;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [6:0] wdata, rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg <= SPACE_CODE;
    end else if (cfg_we) begin
      bg <= cfg_data;
    end
  end

  sor_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .bg, .cmd, .sts, .we, .waddr, .wdata, .raddr, .rdata
  );

  sor_datapath u_dp (.clk, .cmd, .sts);

  sor_ram #(.WIDTH(CODE_W), .DEPTH(CELL_COUNT)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );
endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sor_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  class frame_scoreboard;
    logic [6:0] cells [CELL_COUNT];
    logic [6:0] bg_code;
    out_beat_t  pending [$];
    int         errors;

    function void clear_frame(logic [6:0] code);
      for (int i = 0; i < CELL_COUNT; i++) cells[i] = code;
    endfunction

    function void plot(int row, int col, logic [6:0] code);
      if (row >= 0 && row < CANVAS_HEIGHT && col >= 0 && col < CANVAS_WIDTH)
        cells[row * CANVAS_WIDTH + col] = code;
    endfunction

    function void trace_segment(int xa, int ya, int xb, int yb, logic [6:0] code);
      int dx, dy, sx, sy, err, x, y, e2;
      dx = (xb >= xa) ? xb - xa : xa - xb;
      dy = (yb >= ya) ? yb - ya : ya - yb;
      sx = (xb >= xa) ? 1 : -1;
      sy = (yb >= ya) ? 1 : -1;
      err = dx - dy;
      x = xa;
      y = ya;
      forever begin
        plot(y, x, code);
        if (x == xb && y == yb) break;
        e2 = 2 * err;
        if (e2 > -dy) begin
          err -= dy;
          x += sx;
        end
        if (e2 < dx) begin
          err += dx;
          y += sy;
        end
      end
    endfunction

    function void trace_circle(int cx, int cy, int r, logic [6:0] code);
      int x, y, err;
      x = r;
      y = 0;
      err = 0;
      while (x >= y) begin
        plot(cy + y, cx + x, code);
        plot(cy + x, cx + y, code);
        plot(cy + x, cx - y, code);
        plot(cy + y, cx - x, code);
        plot(cy - y, cx - x, code);
        plot(cy - x, cx - y, code);
        plot(cy - x, cx + y, code);
        plot(cy - y, cx + x, code);
        y++;
        err += 1 + 2 * y;
        if (2 * (err - x) + 1 > 0) begin
          x--;
          err += 1 - 2 * x;
        end
      end
    endfunction

    function void note_command(in_beat_t c);
      out_beat_t r;
      int l, rt, t, b, x1, y1, x2, y2, x3, y3;
      r = '0;
      r.done_action = c.action;
      x1 = int'(c.point1_x);
      y1 = int'(c.point1_y);
      x2 = int'(c.point2_x);
      y2 = int'(c.point2_y);
      x3 = int'(c.point3_x);
      y3 = int'(c.point3_y);
      if (c.action == ACT_CLEAR) begin
        clear_frame(bg_code);
      end else if (c.action == ACT_DRAW) begin
        case (c.shape_kind)
          SHP_CIRCLE: trace_circle(x1, y1, int'(c.radius), c.glyph);
          SHP_RECT: begin
            l  = (x1 < x2) ? x1 : x2;
            rt = (x1 > x2) ? x1 : x2;
            t  = (y1 < y2) ? y1 : y2;
            b  = (y1 > y2) ? y1 : y2;
            trace_segment(l, t, rt, t, c.glyph);
            trace_segment(l, b, rt, b, c.glyph);
            trace_segment(l, t, l, b, c.glyph);
            trace_segment(rt, t, rt, b, c.glyph);
          end
          SHP_LINE: trace_segment(x1, y1, x2, y2, c.glyph);
          default: begin
            trace_segment(x1, y1, x2, y2, c.glyph);
            trace_segment(x2, y2, x3, y3, c.glyph);
            trace_segment(x3, y3, x1, y1, c.glyph);
          end
        endcase
      end else if (c.action == ACT_READ) begin
        if (int'(c.read_row) < CANVAS_HEIGHT && int'(c.read_col) < CANVAS_WIDTH)
          r.cell_value = cells[int'(c.read_row) * CANVAS_WIDTH + int'(c.read_col)];
      end
      pending.push_back(r);
    endfunction

    function void check_completion(out_beat_t got);
      out_beat_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.cell_value !== exp.cell_value) begin
        $display("%0t: cell_value expected %0d actual %0d", $time, exp.cell_value,
                 got.cell_value);
        errors++;
      end
      if (got.done_action !== exp.done_action) begin
        $display("%0t: done_action expected %0d actual %0d", $time, exp.done_action,
                 got.done_action);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;

  frame_scoreboard sb;
  int idle_cycles;
  bit long_hold;

  always #2 clk = ~clk;

  shape_outline_rasterizer_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  task automatic send_command(in_beat_t c);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_command(c);
  endtask

  task automatic write_background(logic [6:0] code);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.bg_code = code;
  endtask

  function automatic in_beat_t random_command();
    in_beat_t c;
    c = in_beat_t'($bits(in_beat_t)'({$urandom, $urandom}));
    case ($urandom_range(0, 19))
      0:           c.action = ACT_CLEAR;
      1:           c.action = ACT_UNUSED;
      2, 3, 4, 5, 6, 7, 8, 9: c.action = ACT_DRAW;
      default:     c.action = ACT_READ;
    endcase
    c.radius = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 12));
    return c;
  endfunction

  function automatic in_beat_t make_draw(logic [1:0] kind, int x1, int y1, int x2, int y2,
                                         int x3, int y3, int r, logic [6:0] g);
    in_beat_t c;
    c = '0;
    c.action = ACT_DRAW;
    c.shape_kind = kind;
    c.point1_x = 6'(x1); c.point1_y = 5'(y1);
    c.point2_x = 6'(x2); c.point2_y = 5'(y2);
    c.point3_x = 6'(x3); c.point3_y = 5'(y3);
    c.radius = 6'(r);
    c.glyph = g;
    return c;
  endfunction

  function automatic in_beat_t make_read(int row, int col);
    in_beat_t c;
    c = '0;
    c.action = ACT_READ;
    c.read_row = 5'(row);
    c.read_col = 6'(col);
    return c;
  endfunction

  // drain results, with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_completion(out_data);
  end

  initial begin
    int wait_cycles;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end
      wait_cycles = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
      if (wait_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [6:0] bgs [4];
    sb = new();
    sb.bg_code = SPACE_CODE;
    sb.clear_frame(SPACE_CODE);
    bgs = '{7'd0, 7'd127, 7'd46, 7'($urandom_range(0, 127))};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_command(make_read(0, 0));
    send_command(make_read(31, 63));
    send_command(make_draw(SHP_LINE, 0, 0, 63, 31, 0, 0, 0, 7'd127));
    send_command(make_draw(SHP_LINE, 63, 31, 0, 0, 0, 0, 0, 7'd0));
    send_command(make_draw(SHP_RECT, 50, 20, 3, 2, 0, 0, 0, 7'd35));
    send_command(make_draw(SHP_TRI, 5, 5, 40, 10, 20, 30, 0, 7'd42));
    send_command(make_draw(SHP_CIRCLE, 32, 16, 0, 0, 0, 0, 0, 7'd64));
    send_command(make_draw(SHP_CIRCLE, 0, 0, 0, 0, 0, 0, 63, 7'd65));
    send_command(make_draw(SHP_CIRCLE, 60, 30, 0, 0, 0, 0, 10, 7'd66));
    send_command(make_draw(SHP_CIRCLE, 32, 16, 0, 0, 0, 0, 32, 7'd67));
    send_command(make_read(16, 32));
    send_command(make_read(2, 3));
    send_command(make_read(31, 31));
    begin
      in_beat_t c;
      c = make_read(5, 5);
      c.action = ACT_UNUSED;
      send_command(c);
    end
    for (int p = 0; p < 4; p++) begin
      write_background(bgs[p]);
      send_command(make_read(0, 0));
      begin
        in_beat_t c;
        c = '0;
        c.action = ACT_CLEAR;
        send_command(c);
      end
      send_command(make_read(7, 9));
      for (int i = 0; i < 120; i++) begin
        if (p == 1 && i == 10) long_hold = 1'b1;
        send_command(random_command());
      end
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ===== files.f =====
sv/sor_pkg.sv
sv/sor_ram.sv
sv/sor_datapath.sv
sv/sor_ctrl.sv
sv/shape_outline_rasterizer_core.sv
bench/tb_top.sv
